/* hdl/caes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caes_pkg
// Shared types and constants of the crank angle event scheduler.
// ----------------------------------------------------------------------------
package caes_pkg;

  localparam logic [25:0] Q_CYCLE = 26'd47185920;
  localparam logic [25:0] Q_HALF  = 26'd23592960;

  localparam logic [24:0] DEG_PER_TOOTH_RST = 25'd393216;
  localparam logic [25:0] TDC_OFFSET_RST    = 26'd7471104;
  localparam logic [25:0] FIRE_WINDOW_RST   = 26'd589824;

  // top shift of the modulo-720 compare and subtract reduction
  localparam logic [2:0] RED_TOP = 3'd6;

  localparam int DIV_N_W = 58;
  localparam int DIV_D_W = 26;

  typedef enum logic [1:0] {
    REG_DEG_PER_TOOTH = 2'd0,
    REG_TDC_OFFSET    = 2'd1,
    REG_FIRE_WINDOW   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_TOOTH      = 3'd0,
    CMD_SCHEDULE   = 3'd1,
    CMD_CANCEL_CYL = 3'd2,
    CMD_CANCEL_KND = 3'd3,
    CMD_CANCEL_ALL = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MUL,
    ST_DIST,
    ST_DIV,
    ST_CAN_RD,
    ST_CAN_CHK,
    ST_EMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cylinder;
    logic [25:0] angle;
    logic [31:0] pulse;
  } slot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cylinder;
    logic [31:0] fire_time;
    logic [31:0] pulse;
  } fire_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_N_W-1:0]   dividend;
    logic [DIV_D_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/caes_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caes_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module caes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/caes_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caes_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module caes_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  caes_pkg::div_req_t           req,
  output caes_pkg::div_stat_t          stat,
  output logic [caes_pkg::DIV_N_W-1:0] quot
);

  localparam int NW = caes_pkg::DIV_N_W;
  localparam int DW = caes_pkg::DIV_D_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dq_r, dq_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  always_comb begin
    trial    = {r_r, dq_r[NW-1]};
    diff     = trial - {1'b0, d_r};
    dq_nxt   = dq_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dq_nxt   = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt  = diff[DW-1:0];
        dq_nxt = {dq_r[NW-2:0], 1'b1};
      end else begin
        r_nxt  = trial[DW-1:0];
        dq_nxt = {dq_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r <= dq_nxt;
    r_r  <= r_nxt;
    d_r  <= d_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dq_r;

endmodule

/* hdl/crank_angle_event_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crank_angle_event_scheduler_unit
// Angle-armed engine event table with tooth-driven firing.
// ----------------------------------------------------------------------------
// One item at a time: in_stall is high from acceptance until the last result
// is taken. Schedule and cancel-all items go straight to their result; cancel
// by cylinder or kind first reads and checks each slot in turn. A tooth item
// is accepted and its angle is reduced modulo 720 degrees by shifted compare
// and subtract; when firing is enabled each slot is then read and checked in
// turn, and each fired slot takes a multiply, then, unless degrees per tooth is
// zero, the shared 58-step divider for the delay. Each result is held until it
// is taken. Slot payload sits in a RAM read one slot per cycle; armed bits are
// flops cleared at reset.
module crank_angle_event_scheduler_unit #(
  parameter int SLOT_COUNT     = 16,
  parameter int CYLINDER_COUNT = 8,
  parameter int KIND_COUNT     = 4,
  parameter int MAX_FIRES      = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_tooth_time,
  input  logic [31:0] in_tooth_period,
  input  logic [6:0]  in_tooth_number,
  input  logic        in_second_revolution,
  input  logic        in_sync_ok,
  input  logic [31:0] in_counter_now,
  input  logic [1:0]  in_event_kind,
  input  logic [2:0]  in_cylinder_number,
  input  logic [25:0] in_target_angle_q,
  input  logic [31:0] in_pulse_width,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fire_valid,
  output logic [1:0]  out_fire_kind,
  output logic [2:0]  out_fire_cylinder,
  output logic [31:0] out_fire_time,
  output logic [31:0] out_fire_pulse,
  output logic        out_last_result,
  output logic        out_schedule_ok,
  output logic [4:0]  out_armed_count,
  output logic [31:0] out_gap_mismatch_count
);

  localparam int SW  = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int FW  = $clog2(MAX_FIRES + 1);
  localparam int FIW = MAX_FIRES > 1 ? $clog2(MAX_FIRES) : 1;
  localparam int SLW = $bits(caes_pkg::slot_t);

  caes_pkg::state_t state_r, state_nxt;

  logic [24:0] deg_r;
  logic [25:0] tdc_r;
  logic [25:0] win_r;

  logic [SLOT_COUNT-1:0] armed_r, armed_nxt;
  logic [CW-1:0]         acnt_r, acnt_nxt;
  logic [31:0]           prev_r, prev_nxt;
  logic [31:0]           mism_r, mism_nxt;

  logic [2:0]  cmd_r, cmd_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] period_r, period_nxt;
  logic        sync_r, sync_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  cyl_r, cyl_nxt;
  logic        sok_r, sok_nxt;
  logic [25:0] angle_r, angle_nxt;
  logic [32:0] red_r, red_nxt;
  logic [2:0]  rstep_r, rstep_nxt;
  logic [25:0] dist_r, dist_nxt;
  logic [57:0] prod_r, prod_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [FW-1:0] nfire_r, nfire_nxt;
  logic [FW-1:0] k_r, k_nxt;
  caes_pkg::slot_t cur_r, cur_nxt;
  caes_pkg::fire_t fbuf_r [MAX_FIRES];
  caes_pkg::fire_t fbuf_nxt [MAX_FIRES];

  logic        ov_r, ov_nxt;
  logic        ofv_r, ofv_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [2:0]  oc_r, oc_nxt;
  logic [31:0] ot_r, ot_nxt;
  logic [31:0] op_r, op_nxt;
  logic        ol_r, ol_nxt;

  caes_pkg::div_req_t  div_req;
  caes_pkg::div_stat_t div_stat;
  logic [57:0]         div_quot;

  logic            ram_we;
  logic [SW-1:0]   ram_waddr;
  caes_pkg::slot_t ram_wdata;
  caes_pkg::slot_t ram_rdata;
  logic [SLW-1:0]  ram_rbits;

  logic        in_acc;
  logic        cfg_wr;
  logic [31:0] in_base;
  logic [31:0] gap;
  logic [32:0] gap_lim;
  logic [32:0] ang_sum;
  logic [32:0] red_cmp;
  logic [32:0] red_sub;
  logic        free_found;
  logic [SW-1:0] free_idx;
  logic [25:0] tgt_red;
  logic [25:0] sdist;
  logic        in_win;
  logic        idx_last;
  logic        fires_full;
  logic        rec_fire;
  logic [31:0] rec_delay;
  logic        can_hit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != caes_pkg::ST_IDLE);

  always_comb begin
    unique case (caes_pkg::reg_idx_t'(paddr[3:2]))
      caes_pkg::REG_DEG_PER_TOOTH: prdata = 32'(deg_r);
      caes_pkg::REG_TDC_OFFSET:    prdata = 32'(tdc_r);
      caes_pkg::REG_FIRE_WINDOW:   prdata = 32'(win_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= caes_pkg::DEG_PER_TOOTH_RST;
      tdc_r <= caes_pkg::TDC_OFFSET_RST;
      win_r <= caes_pkg::FIRE_WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (caes_pkg::reg_idx_t'(paddr[3:2]))
        caes_pkg::REG_DEG_PER_TOOTH: deg_r <= pwdata[24:0];
        caes_pkg::REG_TDC_OFFSET:    tdc_r <= pwdata[25:0];
        caes_pkg::REG_FIRE_WINDOW:   win_r <= pwdata[25:0];
        default: ;
      endcase
    end
  end

  caes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  caes_ram #(
    .WIDTH (SLW),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rbits)
  );

  assign ram_rdata = caes_pkg::slot_t'(ram_rbits);

  // arrival-side arithmetic
  always_comb begin
    in_base = (in_counter_now == 32'd0) ? in_tooth_time : in_counter_now;
    gap     = in_base - prev_r;
    gap_lim = {1'b0, in_tooth_period} + {2'b00, in_tooth_period[31:1]};
    ang_sum = 33'(in_tooth_number) * 33'(deg_r)
            + (in_second_revolution ? 33'(caes_pkg::Q_HALF) : 33'd0)
            + 33'(tdc_r);
    tgt_red = (in_target_angle_q >= caes_pkg::Q_CYCLE) ?
              in_target_angle_q - caes_pkg::Q_CYCLE : in_target_angle_q;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!free_found && !armed_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // scan-side arithmetic
  always_comb begin
    red_cmp = 33'(caes_pkg::Q_CYCLE) << rstep_r;
    red_sub = (red_r >= red_cmp) ? red_r - red_cmp : red_r;
    if (ram_rdata.angle >= angle_r) begin
      sdist = ram_rdata.angle - angle_r;
    end else begin
      sdist = (caes_pkg::Q_CYCLE - angle_r) + ram_rdata.angle;
    end
    in_win     = armed_r[idx_r] && (sdist <= win_r);
    idx_last   = (idx_r == SW'(SLOT_COUNT - 1));
    fires_full = (nfire_r + 1'b1 == FW'(MAX_FIRES));
    can_hit    = armed_r[idx_r] &&
                 (((cmd_r == caes_pkg::CMD_CANCEL_CYL) &&
                   (ram_rdata.cylinder == cyl_r)) ||
                  ((cmd_r == caes_pkg::CMD_CANCEL_KND) &&
                   (ram_rdata.kind == kind_r)));
    rec_fire   = 1'b0;
    rec_delay  = '0;
    if (state_r == caes_pkg::ST_DIST && deg_r == 25'd0) begin
      rec_fire = 1'b1;
    end else if (state_r == caes_pkg::ST_DIV && div_stat.done) begin
      rec_fire  = 1'b1;
      rec_delay = div_quot[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      caes_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority case (in_command)
            caes_pkg::CMD_TOOTH:      state_nxt = caes_pkg::ST_ANGLE;
            caes_pkg::CMD_CANCEL_CYL,
            caes_pkg::CMD_CANCEL_KND: state_nxt = caes_pkg::ST_CAN_RD;
            default:                  state_nxt = caes_pkg::ST_EMIT;
          endcase
        end
      end
      caes_pkg::ST_ANGLE: begin
        if (rstep_r == 3'd0) begin
          state_nxt = (sync_r && period_r != 32'd0) ?
                      caes_pkg::ST_SCAN_RD : caes_pkg::ST_EMIT;
        end
      end
      caes_pkg::ST_SCAN_RD: state_nxt = caes_pkg::ST_SCAN_CHK;
      caes_pkg::ST_SCAN_CHK: begin
        if (in_win) begin
          state_nxt = caes_pkg::ST_MUL;
        end else begin
          state_nxt = idx_last ? caes_pkg::ST_EMIT : caes_pkg::ST_SCAN_RD;
        end
      end
      caes_pkg::ST_MUL: state_nxt = caes_pkg::ST_DIST;
      caes_pkg::ST_DIST, caes_pkg::ST_DIV: begin
        if (rec_fire) begin
          state_nxt = (idx_last || fires_full) ?
                      caes_pkg::ST_EMIT : caes_pkg::ST_SCAN_RD;
        end else if (state_r == caes_pkg::ST_DIST) begin
          state_nxt = caes_pkg::ST_DIV;
        end
      end
      caes_pkg::ST_CAN_RD: state_nxt = caes_pkg::ST_CAN_CHK;
      caes_pkg::ST_CAN_CHK: begin
        state_nxt = idx_last ? caes_pkg::ST_EMIT : caes_pkg::ST_CAN_RD;
      end
      caes_pkg::ST_EMIT: state_nxt = caes_pkg::ST_OUT;
      caes_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ol_r ? caes_pkg::ST_IDLE : caes_pkg::ST_EMIT;
        end
      end
      default: state_nxt = caes_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    armed_nxt  = armed_r;
    acnt_nxt   = acnt_r;
    prev_nxt   = prev_r;
    mism_nxt   = mism_r;
    cmd_nxt    = cmd_r;
    base_nxt   = base_r;
    period_nxt = period_r;
    sync_nxt   = sync_r;
    kind_nxt   = kind_r;
    cyl_nxt    = cyl_r;
    sok_nxt    = sok_r;
    angle_nxt  = angle_r;
    red_nxt    = red_r;
    rstep_nxt  = rstep_r;
    dist_nxt   = dist_r;
    prod_nxt   = prod_r;
    idx_nxt    = idx_r;
    nfire_nxt  = nfire_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    fbuf_nxt   = fbuf_r;
    ov_nxt     = ov_r;
    ofv_nxt    = ofv_r;
    ok_nxt     = ok_r;
    oc_nxt     = oc_r;
    ot_nxt     = ot_r;
    op_nxt     = op_r;
    ol_nxt     = ol_r;
    ram_we     = 1'b0;
    ram_waddr  = free_idx;
    ram_wdata  = '{kind: in_event_kind, cylinder: in_cylinder_number,
                   angle: tgt_red, pulse: in_pulse_width};
    div_req    = '{start: 1'b0, dividend: '0, divisor: '0};

    unique case (state_r)
      caes_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_command;
          base_nxt   = in_base;
          period_nxt = in_tooth_period;
          sync_nxt   = in_sync_ok;
          kind_nxt   = in_event_kind;
          cyl_nxt    = in_cylinder_number;
          sok_nxt    = 1'b0;
          idx_nxt    = '0;
          nfire_nxt  = '0;
          k_nxt      = '0;
          priority case (in_command)
            caes_pkg::CMD_TOOTH: begin
              if (prev_r != 32'd0 && in_tooth_period != 32'd0 &&
                  {1'b0, gap} > gap_lim) begin
                mism_nxt = mism_r + 32'd1;
              end
              prev_nxt  = in_base;
              red_nxt   = ang_sum;
              rstep_nxt = caes_pkg::RED_TOP;
            end
            caes_pkg::CMD_SCHEDULE: begin
              if (32'(in_cylinder_number) < CYLINDER_COUNT &&
                  32'(in_event_kind) < KIND_COUNT && free_found) begin
                ram_we             = 1'b1;
                armed_nxt[free_idx] = 1'b1;
                acnt_nxt           = acnt_r + 1'b1;
                sok_nxt            = 1'b1;
              end
            end
            caes_pkg::CMD_CANCEL_ALL: begin
              armed_nxt = '0;
              acnt_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      caes_pkg::ST_ANGLE: begin
        red_nxt   = red_sub;
        rstep_nxt = rstep_r - 1'b1;
        if (rstep_r == 3'd0) begin
          angle_nxt = red_sub[25:0];
        end
      end
      caes_pkg::ST_SCAN_CHK: begin
        if (in_win) begin
          dist_nxt = sdist;
          cur_nxt  = ram_rdata;
        end else if (!idx_last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      caes_pkg::ST_MUL: begin
        prod_nxt = 58'(dist_r) * 58'(period_r);
      end
      caes_pkg::ST_DIST: begin
        if (!rec_fire) begin
          div_req = '{start: 1'b1, dividend: prod_r, divisor: 26'(deg_r)};
        end
      end
      caes_pkg::ST_CAN_CHK: begin
        if (can_hit) begin
          armed_nxt[idx_r] = 1'b0;
          acnt_nxt         = acnt_r - 1'b1;
        end
        if (!idx_last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      caes_pkg::ST_EMIT: begin
        ov_nxt = 1'b1;
        ol_nxt = (nfire_r == '0) || (k_r + 1'b1 == nfire_r);
        if (nfire_r == '0) begin
          ofv_nxt = 1'b0;
          ok_nxt  = '0;
          oc_nxt  = '0;
          ot_nxt  = '0;
          op_nxt  = '0;
        end else begin
          ofv_nxt = 1'b1;
          ok_nxt  = fbuf_r[k_r[FIW-1:0]].kind;
          oc_nxt  = fbuf_r[k_r[FIW-1:0]].cylinder;
          ot_nxt  = fbuf_r[k_r[FIW-1:0]].fire_time;
          op_nxt  = fbuf_r[k_r[FIW-1:0]].pulse;
        end
      end
      caes_pkg::ST_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          k_nxt  = k_r + 1'b1;
        end
      end
      default: ;
    endcase

    if (rec_fire) begin
      fbuf_nxt[nfire_r[FIW-1:0]] = '{kind: cur_r.kind, cylinder: cur_r.cylinder,
                                     fire_time: base_r + rec_delay,
                                     pulse: cur_r.pulse};
      nfire_nxt        = nfire_r + 1'b1;
      armed_nxt[idx_r] = 1'b0;
      acnt_nxt         = acnt_r - 1'b1;
      if (!idx_last) begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= caes_pkg::ST_IDLE;
      armed_r <= '0;
      acnt_r  <= '0;
      prev_r  <= '0;
      mism_r  <= '0;
      ov_r    <= 1'b0;
      nfire_r <= '0;
      k_r     <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      armed_r <= armed_nxt;
      acnt_r  <= acnt_nxt;
      prev_r  <= prev_nxt;
      mism_r  <= mism_nxt;
      ov_r    <= ov_nxt;
      nfire_r <= nfire_nxt;
      k_r     <= k_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    base_r   <= base_nxt;
    period_r <= period_nxt;
    sync_r   <= sync_nxt;
    kind_r   <= kind_nxt;
    cyl_r    <= cyl_nxt;
    sok_r    <= sok_nxt;
    angle_r  <= angle_nxt;
    red_r    <= red_nxt;
    rstep_r  <= rstep_nxt;
    dist_r   <= dist_nxt;
    prod_r   <= prod_nxt;
    cur_r    <= cur_nxt;
    fbuf_r   <= fbuf_nxt;
    ofv_r    <= ofv_nxt;
    ok_r     <= ok_nxt;
    oc_r     <= oc_nxt;
    ot_r     <= ot_nxt;
    op_r     <= op_nxt;
    ol_r     <= ol_nxt;
  end

  assign out_valid              = ov_r;
  assign out_fire_valid         = ofv_r;
  assign out_fire_kind          = ok_r;
  assign out_fire_cylinder      = oc_r;
  assign out_fire_time          = ot_r;
  assign out_fire_pulse         = op_r;
  assign out_last_result        = ol_r;
  assign out_schedule_ok        = sok_r;
  assign out_armed_count        = 5'(acnt_r);
  assign out_gap_mismatch_count = mism_r;

`ifndef SYNTHESIS
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result shown while input side idle");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'(acnt_r) == $countones(armed_r))
    else $error("armed count out of step with armed bits");

  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nfire_r) <= MAX_FIRES)
    else $error("too many fires recorded");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_result) |=> in_stall)
    else $error("item released before its last result");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule
